// ===== src/rlim_pkg.sv =====
// ============================================================================
// rlim_pkg: shared types and constants of the per-source rate limiter
// Request/response payloads, table entry layout, register indexes, table size.
// ============================================================================
package rlim_pkg;

    // Number of sources tracked in the table (1 to 256).
    localparam int TABLE_ENTRIES = 16;

    // Address width into the table, and a scan counter wide enough to hold the depth.
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] SCAN_DONE = CNT_W'(TABLE_ENTRIES);

    localparam logic [15:0] HITS_MAX = 16'hFFFF;

    // Configuration register indexes.
    localparam int          CFG_IDX_W             = 1;
    localparam logic [0:0]  CFG_WINDOW_LENGTH     = 1'b0;
    localparam logic [0:0]  CFG_REQUEST_THRESHOLD = 1'b1;

    localparam logic [31:0] WINDOW_LENGTH_RESET     = 32'd1000;
    localparam logic [15:0] REQUEST_THRESHOLD_RESET = 16'd100;

    typedef struct packed {
        logic [31:0] source_address;
        logic [31:0] now_tick;
    } t_req;

    typedef struct packed {
        logic        allowed;
        logic [31:0] total_denials;
    } t_rsp;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] win_open;
        logic [15:0] hits;
        logic [31:0] seen_at;
        logic        blocked;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ===== src/rlim_ram.sv =====
// ============================================================================
// rlim_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module rlim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/rlim_alu.sv =====
// ============================================================================
// rlim_alu: shared 32-bit subtract and unsigned compare unit
// Gives a - b modulo 2^32 and the unsigned a < b flag from one subtractor.
// ============================================================================
module rlim_alu (
    input  logic [31:0] i_op_a,
    input  logic [31:0] i_op_b,
    output logic [31:0] o_diff,
    output logic        o_lt
);

    logic [32:0] w_sub;

    // The borrow out of the 33-bit subtract is the unsigned less-than flag.
    assign w_sub  = {1'b0, i_op_a} - {1'b0, i_op_b};
    assign o_diff = w_sub[31:0];
    assign o_lt   = w_sub[32];

endmodule

// ===== src/per_source_rate_limiter_core.sv =====
// ============================================================================
// per_source_rate_limiter_core: per-source fixed-window request rate limiter
// Looks up each request's source in a table, claims a free or least recently
// seen entry on a miss, counts requests per window and flags denied sources.
// ============================================================================
// Flow: requests are taken one at a time; the input stalls from transfer until the result
//   is handed to the output register. The scan reads one table entry per cycle through the
//   single RAM read port.
// Reset (synchronous, active low): clears all entry valid bits, the denial total and
//   the output valid flag, and loads window_length = 1000, request_threshold = 100.
//   No clearing pass is needed; the block takes requests right after reset.
module per_source_rate_limiter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  rlim_pkg::t_req                i_in_data,

    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output rlim_pkg::t_rsp                o_out_data,

    input  logic                          i_cfg_we,
    input  logic [rlim_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    import rlim_pkg::*;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;  // wait for a request
    localparam logic [2:0] S_SCAN = 3'd1;  // read and classify every table entry
    localparam logic [2:0] S_ELAP = 3'd2;  // elapsed = now - window open tick
    localparam logic [2:0] S_EXP  = 3'd3;  // window_length < elapsed -> restart window
    localparam logic [2:0] S_THR  = 3'd4;  // hits >= threshold -> deny
    localparam logic [2:0] S_WR   = 3'd5;  // write the entry back
    localparam logic [2:0] S_OUT  = 3'd6;  // hand the result to the output register

    logic [2:0]              r_state;

    // Configuration.
    logic [31:0]             r_window_length;
    logic [15:0]             r_threshold;

    // Request being worked on.
    t_req                    r_req;

    // Scan bookkeeping: read issue counter, and the entry whose data is on the RAM output.
    logic [CNT_W-1:0]        r_idx;
    logic                    r_rd_v;
    logic [IDX_W-1:0]        r_chk_idx;

    logic                    r_found;
    logic                    r_have_free;
    logic                    r_have_old;
    logic [IDX_W-1:0]        r_free_idx;
    logic [IDX_W-1:0]        r_old_idx;
    logic [31:0]             r_old_ls;

    // Working copy of the selected entry.
    logic [IDX_W-1:0]        r_slot;
    logic [31:0]             r_ws;
    logic [15:0]             r_hits;
    logic                    r_blk;
    logic [31:0]             r_elapsed;

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [31:0]             r_total;

    logic                    r_out_valid;
    t_rsp                    r_out;

    // RAM and shared unit hookup.
    logic                    w_ram_re;
    logic                    w_ram_we;
    logic [ENTRY_W-1:0]      w_ram_rdata;
    t_entry                  w_entry;
    t_entry                  w_wr_entry;

    logic [31:0]             w_alu_a;
    logic [31:0]             w_alu_b;
    logic [31:0]             w_alu_diff;
    logic                    w_alu_lt;

    // Per-entry classification during the scan.
    logic                    w_e_valid;
    logic                    w_hit;
    logic                    w_free_hit;
    logic                    w_old_hit;
    logic                    w_scan_last;

    logic                    n_found;
    logic                    n_have_free;
    logic [IDX_W-1:0]        n_free_idx;
    logic [IDX_W-1:0]        n_old_idx;
    logic [IDX_W-1:0]        n_pick;

    logic [15:0]             w_hits_inc;
    logic                    w_in_xfer;
    logic                    w_out_free;

    // ------------------------------------------------------------------------
    // Table storage and the shared subtract/compare unit
    // ------------------------------------------------------------------------
    rlim_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_slot),
        .i_wdata (w_wr_entry),
        .i_re    (w_ram_re),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (w_ram_rdata)
    );

    assign w_entry = t_entry'(w_ram_rdata);

    rlim_alu u_alu (
        .i_op_a (w_alu_a),
        .i_op_b (w_alu_b),
        .o_diff (w_alu_diff),
        .o_lt   (w_alu_lt)
    );

    // Steer the shared unit by state.
    always_comb begin
        case (r_state)
            S_SCAN: begin
                w_alu_a = w_entry.seen_at;
                w_alu_b = r_old_ls;
            end
            S_ELAP: begin
                w_alu_a = r_req.now_tick;
                w_alu_b = r_ws;
            end
            S_EXP: begin
                w_alu_a = r_window_length;
                w_alu_b = r_elapsed;
            end
            S_THR: begin
                w_alu_a = {16'd0, r_hits};
                w_alu_b = {16'd0, r_threshold};
            end
            default: begin
                w_alu_a = 32'd0;
                w_alu_b = 32'd0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Scan classification
    // ------------------------------------------------------------------------
    // Issue one read per cycle until every entry has been requested.
    assign w_ram_re   = (r_state == S_SCAN) && (r_idx != SCAN_DONE);
    assign w_e_valid  = r_valid[r_chk_idx];

    // First valid entry whose key matches the source wins.
    assign w_hit      = r_rd_v && w_e_valid && !r_found
                        && (w_entry.key == r_req.source_address);
    // Lowest free entry.
    assign w_free_hit = r_rd_v && !w_e_valid && !r_have_free;
    // Strictly older valid entry replaces the candidate, so ties keep the lower index.
    assign w_old_hit  = r_rd_v && w_e_valid && (!r_have_old || w_alu_lt);
    assign w_scan_last = r_rd_v && (r_chk_idx == LAST_IDX);

    assign n_found     = r_found | w_hit;
    assign n_have_free = r_have_free | w_free_hit;
    assign n_free_idx  = w_free_hit ? r_chk_idx : r_free_idx;
    assign n_old_idx   = w_old_hit ? r_chk_idx : r_old_idx;

    // Victim when nothing matched: lowest free entry, else least recently seen.
    assign n_pick      = n_have_free ? n_free_idx : n_old_idx;

    // Saturating count of the current window.
    assign w_hits_inc  = (r_hits == HITS_MAX) ? r_hits : r_hits + 16'd1;

    assign w_ram_we    = (r_state == S_WR);
    always_comb begin
        w_wr_entry.key      = r_req.source_address;
        w_wr_entry.win_open = r_ws;
        w_wr_entry.hits     = r_hits;
        w_wr_entry.seen_at  = r_req.now_tick;
        w_wr_entry.blocked  = r_blk;
    end

    // ------------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------------
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_window_length <= WINDOW_LENGTH_RESET;
            r_threshold     <= REQUEST_THRESHOLD_RESET;
            r_valid         <= '0;
            r_total         <= 32'd0;
            r_out_valid     <= 1'b0;
            r_rd_v          <= 1'b0;
        end else begin
            // Load the register that the index selects on every write.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WINDOW_LENGTH:     r_window_length <= i_cfg_data;
                    CFG_REQUEST_THRESHOLD: r_threshold     <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            // Raise the result when the sequencer hands it over; drop it once taken.
            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            r_rd_v <= w_ram_re;

            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_scan_last) begin
                        r_state <= S_ELAP;
                    end
                end
                S_ELAP: r_state <= S_EXP;
                S_EXP:  r_state <= S_THR;
                S_THR: begin
                    // Count reached the threshold in this window: deny, and bump the total if not yet denied.
                    if (!w_alu_lt && !r_blk) begin
                        r_total <= r_total + 32'd1;
                    end
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_valid[r_slot] <= 1'b1;
                    r_state         <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    r_req       <= i_in_data;
                    r_idx       <= '0;
                    r_found     <= 1'b0;
                    r_have_free <= 1'b0;
                    r_have_old  <= 1'b0;
                end
            end
            S_SCAN: begin
                if (w_ram_re) begin
                    r_idx     <= r_idx + CNT_W'(1);
                    r_chk_idx <= r_idx[IDX_W-1:0];
                end
                if (w_hit) begin
                    r_found <= 1'b1;
                    r_slot  <= r_chk_idx;
                    r_ws    <= w_entry.win_open;
                    r_hits  <= w_entry.hits;
                    r_blk   <= w_entry.blocked;
                end
                if (w_free_hit) begin
                    r_have_free <= 1'b1;
                    r_free_idx  <= r_chk_idx;
                end
                if (w_old_hit) begin
                    r_have_old <= 1'b1;
                    r_old_idx  <= r_chk_idx;
                    r_old_ls   <= w_entry.seen_at;
                end
                // Miss: claim the victim and start a fresh window at this tick.
                if (w_scan_last && !n_found) begin
                    r_slot <= n_pick;
                    r_ws   <= r_req.now_tick;
                    r_hits <= 16'd0;
                    r_blk  <= 1'b0;
                end
            end
            S_ELAP: begin
                r_elapsed <= w_alu_diff;
            end
            S_EXP: begin
                // Window_length below elapsed means the window has run out.
                if (w_alu_lt) begin
                    r_ws   <= r_req.now_tick;
                    r_hits <= 16'd1;
                    r_blk  <= 1'b0;
                end else begin
                    r_hits <= w_hits_inc;
                end
            end
            S_THR: begin
                if (!w_alu_lt) begin
                    r_blk <= 1'b1;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_out.allowed       <= !r_blk;
                    r_out.total_denials <= r_total;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== sim/tb_per_source_rate_limiter_core.sv =====
// ============================================================================
// tb_per_source_rate_limiter_core: self-checking bench of the rate limiter
// Directed requests cover the register extremes, window restart and wrap, and
// table eviction. Random traffic phases follow, each with its own limits. A
// predictor inside the bench tracks the source table and the denial total,
// and each result transfer is checked against the oldest expected verdict.
// ============================================================================
module tb_per_source_rate_limiter_core;

    import rlim_pkg::*;

    localparam int          RESULT_LATENCY   = TABLE_ENTRIES + 6;
    localparam int          SETTLE_CYCLES    = RESULT_LATENCY + 8;
    localparam int          LONG_HOLD_CYCLES = 400;
    localparam int          CYCLE_LIMIT      = 1000000;
    localparam int          POOL_MAX         = 32;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;

    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_req                 in_data   = '0;

    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_rsp                 out_data;

    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_WINDOW_LENGTH;
    logic [31:0]          cfg_data  = '0;

    always #5 clk = ~clk;

    per_source_rate_limiter_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the source table and the limits
    // ------------------------------------------------------------------------
    logic [31:0] src_key    [TABLE_ENTRIES];
    logic        src_live   [TABLE_ENTRIES];
    logic [31:0] src_start  [TABLE_ENTRIES];
    logic [15:0] src_hits   [TABLE_ENTRIES];
    logic [31:0] src_seen   [TABLE_ENTRIES];
    logic        src_denied [TABLE_ENTRIES];
    logic [31:0] denial_count  = '0;
    logic [31:0] cfg_window    = WINDOW_LENGTH_RESET;
    logic [15:0] cfg_threshold = REQUEST_THRESHOLD_RESET;

    // Verdicts still owed by the block, oldest first.
    t_rsp verdict_q [$];

    int  fail_count    = 0;
    int  cycle_count   = 0;
    int  next_gap      = 0;
    int  tx_calm_left  = 0;
    bit  long_hold_req = 1'b0;

    initial begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            src_live[i] = 1'b0;
        end
    end

    // Update the table for one request and return the verdict it earns.
    function automatic t_rsp predict_verdict(input t_req req);
        int          slot;
        int          open_slot;
        int          oldest;
        bit          hit;
        logic [31:0] elapsed;
        t_rsp        rsp;
        slot      = -1;
        open_slot = -1;
        oldest    = -1;
        hit       = 1'b0;
        // Scan in index order: the first match wins, otherwise remember the
        // first free entry and the entry seen longest ago (lowest index on ties).
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!hit) begin
                if (src_live[i] && src_key[i] == req.source_address) begin
                    hit  = 1'b1;
                    slot = i;
                end else if (!src_live[i]) begin
                    if (open_slot < 0) open_slot = i;
                end else if (oldest < 0 || src_seen[i] < src_seen[oldest]) begin
                    oldest = i;
                end
            end
        end
        // Claim an entry on a miss and open a fresh window at the request tick.
        if (!hit) begin
            slot             = (open_slot >= 0) ? open_slot : oldest;
            src_key[slot]    = req.source_address;
            src_start[slot]  = req.now_tick;
            src_hits[slot]   = '0;
            src_denied[slot] = 1'b0;
            src_live[slot]   = 1'b1;
        end
        src_seen[slot] = req.now_tick;
        // Restart the window once more than the window length has elapsed.
        elapsed = req.now_tick - src_start[slot];
        if (elapsed > cfg_window) begin
            src_start[slot]  = req.now_tick;
            src_hits[slot]   = '0;
            src_denied[slot] = 1'b0;
        end
        if (src_hits[slot] != HITS_MAX) src_hits[slot] = src_hits[slot] + 16'd1;
        // Deny once per window, on reaching the threshold.
        if (src_hits[slot] >= cfg_threshold && !src_denied[slot]) begin
            src_denied[slot] = 1'b1;
            denial_count     = denial_count + 32'd1;
        end
        rsp.allowed       = !src_denied[slot];
        rsp.total_denials = denial_count;
        return rsp;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // Mostly short gaps, a few long ones, and now and then a run with none.
    function automatic int pick_gap();
        int r;
        if (tx_calm_left > 0) begin
            tx_calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            tx_calm_left = $urandom_range(10, 30);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one request and hold it until the block takes it. With more set,
    // keep valid up when the next request follows without a gap; otherwise
    // drop valid in the step of the transfer.
    task automatic send_request(input logic [31:0] addr, input logic [31:0] tick,
                                input bit more);
        t_req req;
        req.source_address = addr;
        req.now_tick       = tick;
        repeat (next_gap) @(posedge clk);
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall);
        verdict_q.push_back(predict_verdict(req));
        next_gap = more ? pick_gap() : 0;
        if (!more || next_gap != 0) in_valid <= 1'b0;
    endtask

    // Wait until every verdict is in, then let the pipeline settle.
    task automatic wait_idle();
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both limits on back-to-back edges while the block is idle.
    // Junk in the upper half of the threshold write must be ignored.
    task automatic set_limits(input logic [31:0] window, input logic [15:0] threshold);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WINDOW_LENGTH;
        cfg_data  <= window;
        @(posedge clk);
        cfg_index <= CFG_REQUEST_THRESHOLD;
        cfg_data  <= {16'($urandom_range(0, 65535)), threshold};
        @(posedge clk);
        cfg_we        <= 1'b0;
        cfg_window    = window;
        cfg_threshold = threshold;
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: random stalls, calm stretches, and one long hold on demand
    // ------------------------------------------------------------------------
    initial begin : rx_pacing
        int stall_left;
        int calm_left;
        int r;
        stall_left = 0;
        calm_left  = 0;
        forever begin
            @(posedge clk);
            if (long_hold_req) begin
                // Hold off long enough for the block to back up into its input.
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                stall_left = 0;
                calm_left  = 0;
            end else if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else if (calm_left > 0) begin
                out_stall <= 1'b0;
                calm_left--;
            end else begin
                out_stall <= 1'b0;
                r = $urandom_range(0, 99);
                if (r < 5) calm_left = $urandom_range(50, 200);
                else if (r < 25) stall_left = $urandom_range(1, 3);
                else if (r < 28) stall_left = $urandom_range(15, 60);
                else calm_left = $urandom_range(0, 4);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each result transfer with the oldest verdict
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        t_rsp want;
        if (rst_n && out_valid && !out_stall) begin
            if (verdict_q.size() == 0) begin
                $error("result transfer with no request outstanding: allowed=%0d total=%0d",
                       out_data.allowed, out_data.total_denials);
                fail_count++;
            end else begin
                want = verdict_q.pop_front();
                if (out_data.allowed !== want.allowed) begin
                    $error("allowed: expected %0d, got %0d", want.allowed, out_data.allowed);
                    fail_count++;
                end
                if (out_data.total_denials !== want.total_denials) begin
                    $error("total_denials: expected %0d, got %0d",
                           want.total_denials, out_data.total_denials);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_per_source_rate_limiter_core: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------
    // Run on the reset limits with the extreme address and tick values.
    task automatic test_reset_defaults();
        send_request(32'h0000_0000, 32'h0000_0000, 1'b1);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    endtask

    // Threshold of one: the first request of a window denies its source, and
    // the source stays denied without bumping the total again.
    task automatic test_threshold_one();
        set_limits(32'hFFFF_FFFF, 16'd1);
        send_request(32'h0A00_0001, 32'd5, 1'b1);
        send_request(32'h0A00_0001, 32'd6, 1'b0);
    endtask

    // Shortest window: an elapsed time equal to the window keeps the count,
    // one more tick restarts it. Repeat across the tick wrap.
    task automatic test_window_restart();
        set_limits(32'd1, 16'd2);
        send_request(32'hC0A8_0001, 32'd10, 1'b1);
        send_request(32'hC0A8_0001, 32'd11, 1'b1);
        send_request(32'hC0A8_0001, 32'd12, 1'b1);
        send_request(32'h7F00_0001, 32'hFFFF_FFFF, 1'b1);
        send_request(32'h7F00_0001, 32'h0000_0000, 1'b1);
        send_request(32'h7F00_0001, 32'h0000_0001, 1'b0);
    endtask

    // Highest threshold: an expired window on a denied source clears it.
    task automatic test_threshold_max();
        set_limits(32'd1000, 16'hFFFF);
        send_request(32'h0A00_0001, 32'd2000, 1'b0);
    endtask

    // Overfill the table at one tick: evict oldest first, then tied entries
    // by lowest index. Start from an idle block.
    task automatic test_lru_eviction();
        wait_idle();
        for (int i = 0; i < 17; i++) begin
            send_request(32'hE000_0000 | 32'(i), 32'd7000, i != 16);
        end
    endtask

    // ------------------------------------------------------------------------
    // Random traffic
    // ------------------------------------------------------------------------
    // One phase: a pool of sources with a rising tick, plus some noise with
    // random addresses and ticks out of order. Optionally start the long hold.
    task automatic run_traffic(input int count, input logic [31:0] window,
                               input logic [15:0] threshold, input int pool_n,
                               input logic [31:0] max_step, input bit hold);
        logic [31:0] pool [POOL_MAX];
        logic [31:0] tick;
        logic [31:0] addr;
        logic [31:0] stamp;
        set_limits(window, threshold);
        for (int i = 0; i < pool_n; i++) begin
            pool[i] = $urandom;
        end
        tick = $urandom;
        for (int k = 0; k < count; k++) begin
            if (hold && k == count / 4) long_hold_req = 1'b1;
            tick = tick + $urandom_range(0, max_step);
            if ($urandom_range(0, 9) == 0) begin
                addr  = $urandom;
                stamp = $urandom;
            end else begin
                addr  = pool[$urandom_range(0, pool_n - 1)];
                stamp = tick;
            end
            send_request(addr, stamp, k != count - 1);
        end
    endtask

    task automatic test_random_traffic();
        run_traffic(300, 32'd20, 16'd4, 6, 32'd8, 1'b0);
        // Register extremes: tightest and loosest limits.
        run_traffic(200, 32'd1, 16'd1, 20, 32'd3, 1'b0);
        run_traffic(150, 32'hFFFF_FFFF, 16'hFFFF, 24, 32'hFFFF_FFFF, 1'b0);
        for (int p = 0; p < 4; p++) begin
            if (p == 3) begin
                run_traffic(200, $urandom_range(1, 32'hFFFF_FFFF),
                            16'($urandom_range(1, 65535)), 18, 32'hFFFF, 1'b0);
            end else begin
                run_traffic(200, $urandom_range(1, 200), 16'($urandom_range(1, 12)),
                            $urandom_range(4, 24), $urandom_range(1, 40), 1'b0);
            end
        end
    endtask

    // Long receiver hold while requests keep coming, to back the block up.
    task automatic test_backpressure();
        run_traffic(300, 32'd50, 16'd5, 10, 32'd10, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_threshold_one();
        test_window_restart();
        test_threshold_max();
        test_lru_eviction();
        test_random_traffic();
        test_backpressure();
        wait_idle();
        if (fail_count == 0) begin
            $display("tb_per_source_rate_limiter_core: PASS");
        end else begin
            $display("tb_per_source_rate_limiter_core: FAIL");
        end
        $finish;
    end

endmodule
